### sv/scd_pkg.sv
// shared types, constants and the code distance function of the disparity search
`default_nettype none
package scd_pkg;

    localparam int unsigned CODE_W  = 16;
    localparam int unsigned MIN_W   = 9;
    localparam int unsigned MAX_W   = 10;
    localparam int unsigned DISP_W  = 10;
    localparam int unsigned HI_W    = 12;
    localparam int unsigned BD_W    = 11;
    localparam int unsigned BEST_W  = 9;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [BEST_W-1:0] BEST_START  = 9'd256;
    localparam logic [MIN_W-1:0]  MIN_RESET   = 9'd100;
    localparam logic [MAX_W-1:0]  MAX_RESET   = 10'd500;
    localparam logic              HAM_RESET   = 1'b1;
    localparam logic [BD_W-1:0]   DISP_SAT    = 11'd512;

    localparam logic [1:0] REG_MIN_DISP = 2'd0;
    localparam logic [1:0] REG_MAX_DISP = 2'd1;
    localparam logic [1:0] REG_HAM_MODE = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] lcode;
        logic [MIN_W-1:0]  min_disp;
        logic [HI_W-1:0]   hi;
        logic              ham;
    } t_srch;

    typedef struct packed {
        logic [BEST_W-1:0] score;
        logic [BD_W-1:0]   disp;
    } t_best;

    function automatic logic [CODE_W-1:0] code_dist(
        input logic [CODE_W-1:0] a,
        input logic [CODE_W-1:0] b,
        input logic [CODE_W-1:0] mask,
        input logic              ham
    );
        logic [CODE_W-1:0] x;
        logic [CODE_W-1:0] n;
        x = (a ^ b) & mask;
        n = '0;
        if (ham) begin
            for (int i = 0; i < CODE_W; i++) begin
                n = n + CODE_W'(x[i]);
            end
        end else begin
            n = (a > b) ? (a - b) : (b - a);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### sv/scd_ifs.sv
// pixel and result channel interfaces
`default_nettype none
interface scd_in_if;
    logic                       valid;
    logic                       ready;
    logic [scd_pkg::CODE_W-1:0] left_code;
    logic [scd_pkg::CODE_W-1:0] right_code;
    logic                       row_last;

    modport source (output valid, left_code, right_code, row_last, input ready);
    modport sink   (input valid, left_code, right_code, row_last, output ready);
endinterface

interface scd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [scd_pkg::DISP_W-1:0] disparity;
    logic                              row_done;

    modport source (output valid, disparity, row_done, input ready);
    modport sink   (input valid, disparity, row_done, output ready);
endinterface
`default_nettype wire

### sv/scd_cell.sv
// one window cell: holds a right code and passes the running best match down the row
`default_nettype none
module scd_cell #(
    parameter int unsigned D         = 1,
    parameter int unsigned CODE_BITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_shift,
    input  wire logic [scd_pkg::CODE_W-1:0] i_code,
    output logic      [scd_pkg::CODE_W-1:0] o_code,
    input  wire scd_pkg::t_srch             i_srch,
    input  wire scd_pkg::t_best             i_best,
    output scd_pkg::t_best                  o_best
);

    localparam logic [scd_pkg::CODE_W-1:0] MASK =
        scd_pkg::CODE_W'((32'd1 << CODE_BITS) - 32'd1);
    localparam logic [scd_pkg::HI_W-1:0] D_HI = scd_pkg::HI_W'(D);

    logic [scd_pkg::CODE_W-1:0] r_code;
    logic [scd_pkg::CODE_W-1:0] w_dist;
    logic                       w_hit;
    scd_pkg::t_best             r_best;
    scd_pkg::t_best             n_best;

    always_comb begin
        w_dist = scd_pkg::code_dist(r_code, i_srch.lcode, MASK, i_srch.ham);
        w_hit  = (i_srch.lcode != '0) && (r_code != '0)
              && (D_HI > scd_pkg::HI_W'(i_srch.min_disp)) && (D_HI <= i_srch.hi);
        if (w_hit && (w_dist < scd_pkg::CODE_W'(i_best.score))) begin
            n_best.score = w_dist[scd_pkg::BEST_W-1:0];
            n_best.disp  = scd_pkg::BD_W'(D);
        end else begin
            n_best = i_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_code <= i_code;
        end
        r_best <= n_best;
    end

    assign o_code = r_code;
    assign o_best = r_best;

endmodule
`default_nettype wire

### sv/scanline_code_disparity_search.sv
// top level of the scanline code disparity search
//
// i_pix takes one beat per pixel in raster order: left_code, right_code and
// row_last. o_res gives one beat per pixel: disparity (best right column
// minus left column, 0 if none) and row_done. Registers sit on the APB port
// at byte addresses 0 (min_disparity), 4 (max_disparity), 8 (hamming_mode).
// A row of WINDOW_DEPTH cells holds the right codes of the current row; the
// running best match walks one cell per cycle from the deepest cell to cell
// 0, so an item passes a search through all the cells and then a finish
// that registers its result onto o_res; a new beat is taken only after
// that finish, once the block is idle again, so pixels are searched in turn.
// The output register lets the next pixel be taken and searched while a
// result waits; when the receiver stalls, the finish of that next pixel
// waits until the previous result is taken. Reset clears the column, the
// handshake state and loads the register defaults (100, 500, 1); window
// cells are only read at columns written since the row began.
`default_nettype none
module scanline_code_disparity_search #(
    parameter int unsigned WINDOW_DEPTH   = 512,
    parameter int unsigned LINE_WIDTH_MAX = 2048,
    parameter int unsigned CODE_BITS      = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [scd_pkg::PDATA_W-1:0] pwdata,
    output logic      [scd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    scd_in_if.sink                           i_pix,
    scd_out_if.source                        o_res
);

    localparam int unsigned COL_W = $clog2(LINE_WIDTH_MAX);
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH_MAX - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH - 1);
    localparam logic [scd_pkg::HI_W-1:0] DEPTH_HI = scd_pkg::HI_W'(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_cnt;
    logic [COL_W-1:0]            r_col;
    logic [scd_pkg::MIN_W-1:0]   r_min;
    logic [scd_pkg::MAX_W-1:0]   r_max;
    logic                        r_ham;
    logic [scd_pkg::CODE_W-1:0]  r_lcode;
    logic [scd_pkg::CODE_W-1:0]  r_rcode;
    logic                        r_last;
    logic [scd_pkg::HI_W-1:0]    r_hi;
    logic                        r_ovalid;
    logic [scd_pkg::DISP_W-1:0]  r_disp;
    logic                        r_rdone;

    logic                        w_acc;
    logic                        w_fin;
    logic                        w_cfg_wr;
    logic [scd_pkg::HI_W-1:0]    w_hi;
    logic [scd_pkg::BD_W-1:0]    w_sat;
    scd_pkg::t_srch              w_srch;
    logic [scd_pkg::CODE_W-1:0]  w_code [WINDOW_DEPTH];
    scd_pkg::t_best              w_best [WINDOW_DEPTH+1];

    assign w_acc    = i_pix.valid && i_pix.ready;
    assign w_fin    = (r_state == S_DONE) && (!r_ovalid || o_res.ready);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        w_hi = scd_pkg::HI_W'(r_max);
        if (w_hi > DEPTH_HI) begin
            w_hi = DEPTH_HI;
        end
        if (w_hi > scd_pkg::HI_W'(r_col)) begin
            w_hi = scd_pkg::HI_W'(r_col);
        end
    end

    always_comb begin
        w_srch.lcode    = r_lcode;
        w_srch.min_disp = r_min;
        w_srch.hi       = r_hi;
        w_srch.ham      = r_ham;
    end

    assign w_best[WINDOW_DEPTH] = '{score: scd_pkg::BEST_START, disp: '0};

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        scd_cell #(
            .D         (k + 1),
            .CODE_BITS (CODE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_fin),
            .i_code  ((k == 0) ? r_rcode : w_code[(k == 0) ? 0 : k - 1]),
            .o_code  (w_code[k]),
            .i_srch  (w_srch),
            .i_best  (w_best[k+1]),
            .o_best  (w_best[k])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_sat = (w_best[0].disp > scd_pkg::DISP_SAT) ? scd_pkg::DISP_SAT
                                                         : w_best[0].disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
            r_min    <= scd_pkg::MIN_RESET;
            r_max    <= scd_pkg::MAX_RESET;
            r_ham    <= scd_pkg::HAM_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_fin) begin
                r_ovalid <= 1'b1;
                if (r_last) begin
                    r_col <= '0;
                end else if (r_col < COL_LAST) begin
                    r_col <= r_col + 1'b1;
                end
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    scd_pkg::REG_MIN_DISP: r_min <= pwdata[scd_pkg::MIN_W-1:0];
                    scd_pkg::REG_MAX_DISP: r_max <= pwdata[scd_pkg::MAX_W-1:0];
                    scd_pkg::REG_HAM_MODE: r_ham <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_lcode <= i_pix.left_code;
            r_rcode <= i_pix.right_code;
            r_last  <= i_pix.row_last;
            r_hi    <= w_hi;
        end
        if (w_fin) begin
            r_disp  <= scd_pkg::DISP_W'(11'd1024 - w_sat);
            r_rdone <= r_last;
        end
    end

    always_comb begin
        case (paddr[3:2])
            scd_pkg::REG_MIN_DISP: prdata = scd_pkg::PDATA_W'(r_min);
            scd_pkg::REG_MAX_DISP: prdata = scd_pkg::PDATA_W'(r_max);
            scd_pkg::REG_HAM_MODE: prdata = scd_pkg::PDATA_W'(r_ham);
            default:               prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign i_pix.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.disparity = $signed(r_disp);
    assign o_res.row_done  = r_rdone;

endmodule
`default_nettype wire

### sv/scd_chk.sv
// port checker for the disparity search and its bind
`default_nettype none
module scd_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [scd_pkg::DISP_W-1:0] i_disparity,
    input wire logic                              i_row_done,
    input wire logic                              i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_disparity) && $stable(i_row_done))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not empty after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second pixel taken while a search runs");

    a_disp_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_disparity[scd_pkg::DISP_W-1] || i_disparity == '0))
        else $error("positive disparity");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("register port stalled");

endmodule

bind scanline_code_disparity_search scd_chk u_scd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_disparity (o_res.disparity),
    .i_row_done  (o_res.row_done),
    .i_pready    (pready)
);
`default_nettype wire

### test/tb_scanline_code_disparity_search.sv
// testbench for the scanline code disparity search: predicted results against the block
`default_nettype none
module tb_scanline_code_disparity_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH   = 512;
    localparam int LINE_MAX    = 2048;
    localparam int LOW_BITS    = 6;
    localparam int SEARCH_LAT  = WIN_DEPTH + 2;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic signed [scd_pkg::DISP_W-1:0] disparity;
        logic                              row_done;
    } t_pixel_result;

    class t_disparity_tracker;
        logic [scd_pkg::CODE_W-1:0] win [WIN_DEPTH];
        int unsigned                column;
        logic [scd_pkg::MIN_W-1:0]  min_d;
        logic [scd_pkg::MAX_W-1:0]  max_d;
        logic                       ham;
        t_pixel_result              expected_q [$];
        int                         mismatches;

        function new();
            foreach (win[k]) win[k] = '0;
            column     = 0;
            min_d      = scd_pkg::MIN_RESET;
            max_d      = scd_pkg::MAX_RESET;
            ham        = scd_pkg::HAM_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [scd_pkg::PDATA_W-1:0] val);
            case (idx)
                scd_pkg::REG_MIN_DISP: begin
                    min_d = val[scd_pkg::MIN_W-1:0];
                end
                scd_pkg::REG_MAX_DISP: begin
                    max_d = val[scd_pkg::MAX_W-1:0];
                end
                scd_pkg::REG_HAM_MODE: begin
                    ham = val[0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned code_gap(logic [scd_pkg::CODE_W-1:0] a,
                                       logic [scd_pkg::CODE_W-1:0] b);
            logic [scd_pkg::CODE_W-1:0] x;
            int unsigned                n;
            n = 0;
            if (ham) begin
                x = a ^ b;
                for (int i = 0; i < LOW_BITS; i++) n += x[i];
            end else begin
                n = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
            end
            return n;
        endfunction

        function void take_pixel(logic [scd_pkg::CODE_W-1:0] l,
                                 logic [scd_pkg::CODE_W-1:0] r, logic last);
            int unsigned   hi;
            int unsigned   best;
            int unsigned   gap;
            int unsigned   best_d;
            t_pixel_result res;
            best_d = 0;
            if (l != '0) begin
                hi   = max_d;
                best = scd_pkg::BEST_START;
                if (hi > WIN_DEPTH) hi = WIN_DEPTH;
                if (hi > column) hi = column;
                for (int d = hi; d > int'(min_d); d--) begin
                    if (win[d-1] != '0) begin
                        gap = code_gap(win[d-1], l);
                        if (gap < best) begin
                            best   = gap;
                            best_d = d;
                        end
                    end
                end
            end
            if (best_d > 512) best_d = 512;
            res.disparity = scd_pkg::DISP_W'(1024 - best_d);
            res.row_done  = last;
            expected_q.push_back(res);
            for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
            win[0] = r;
            if (last) column = 0;
            else if (column < LINE_MAX - 1) column++;
        endfunction

        function void check_result(logic signed [scd_pkg::DISP_W-1:0] disp, logic rd);
            t_pixel_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: disparity %0d row_done %b", disp, rd);
                return;
            end
            want = expected_q.pop_front();
            if (disp !== want.disparity || rd !== want.row_done) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result mismatch: expected disparity %0d row_done %b, got %0d %b",
                             want.disparity, want.row_done, disp, rd);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [scd_pkg::PADDR_W-1:0]  paddr;
    logic [scd_pkg::PDATA_W-1:0]  pwdata;
    wire  [scd_pkg::PDATA_W-1:0]  prdata;
    wire                          pready;

    scd_in_if  pix_if ();
    scd_out_if res_if ();

    scanline_code_disparity_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    t_disparity_tracker tracker = new();
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_result(res_if.disparity, res_if.row_done);
    end

    task automatic apb_write(input logic [1:0] idx, input logic [scd_pkg::PDATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_search(input int unsigned mn, input int unsigned mx, input logic hm);
        apb_write(scd_pkg::REG_MIN_DISP, scd_pkg::PDATA_W'(mn));
        apb_write(scd_pkg::REG_MAX_DISP, scd_pkg::PDATA_W'(mx));
        apb_write(scd_pkg::REG_HAM_MODE, scd_pkg::PDATA_W'(hm));
    endtask

    task automatic send_pixel(input logic [scd_pkg::CODE_W-1:0] l,
                              input logic [scd_pkg::CODE_W-1:0] r,
                              input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid      = 1'b1;
        pix_if.left_code  = l;
        pix_if.right_code = r;
        pix_if.row_last   = last;
        do @(posedge i_clk); while (!pix_if.ready);
        tracker.take_pixel(l, r, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pix_if.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [scd_pkg::CODE_W-1:0] pick_code(
        logic [scd_pkg::CODE_W-1:0] base, int zero_odds);
        int k;
        k = $urandom_range(zero_odds - 1);
        if (k == 0) return '0;
        if (k == 1) return scd_pkg::CODE_W'($urandom);
        return base + scd_pkg::CODE_W'($urandom_range(300));
    endfunction

    task automatic send_row(input int len);
        logic [scd_pkg::CODE_W-1:0] base;
        base = scd_pkg::CODE_W'($urandom);
        for (int i = 0; i < len; i++)
            send_pixel(pick_code(base, 10), pick_code(base, 16), i == len - 1);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n, input bit long_row);
        int sent;
        int len;
        drain();
        in_idle_pct   = idle;
        out_stall_pct = stall;
        sent = 0;
        if (long_row) begin
            set_search(0, 512, $urandom_range(1));
            send_row(n);
            sent = n;
        end else begin
            set_search(($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(30),
                       ($urandom_range(3) == 0) ? $urandom_range(512) : $urandom_range(20, 90),
                       $urandom_range(1));
        end
        while (sent < n) begin
            len = $urandom_range(1, 80);
            if (len > n - sent) len = n - sent;
            send_row(len);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        pix_if.valid         = 1'b0;
        pix_if.left_code     = '0;
        pix_if.right_code    = '0;
        pix_if.row_last      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults leave the search range empty on short rows
        send_pixel(16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'h0001, 16'h0002, 1'b0);
        send_pixel(16'h0000, 16'h0000, 1'b1);

        // bit count over low code bits, full range
        drain();
        set_search(0, 512, 1'b1);
        send_pixel(16'h0000, 16'h003F, 1'b0);
        send_pixel(16'h0040, 16'h0000, 1'b0);
        send_pixel(16'h003F, 16'h0015, 1'b0);
        send_pixel(16'h002A, 16'h002A, 1'b0);
        send_pixel(16'h0015, 16'hFFFF, 1'b1);
        // new row: old window entries stay out of reach
        send_pixel(16'h0015, 16'h0015, 1'b0);
        send_pixel(16'h0015, 16'h8000, 1'b1);

        // absolute difference, threshold at 256
        drain();
        apb_write(scd_pkg::REG_HAM_MODE, 32'd0);
        send_pixel(16'h0100, 16'h1000, 1'b0);
        send_pixel(16'h1100, 16'h10FF, 1'b0);
        send_pixel(16'h1000, 16'h2000, 1'b0);
        send_pixel(16'hFFFF, 16'h0001, 1'b0);
        send_pixel(16'h0001, 16'h0000, 1'b1);

        // empty ranges at the register extremes
        drain();
        apb_write(scd_pkg::REG_MIN_DISP, 32'd511);
        send_pixel(16'h0001, 16'h0001, 1'b0);
        send_pixel(16'h0001, 16'h0001, 1'b0);
        send_pixel(16'h0001, 16'h0001, 1'b1);
        drain();
        set_search(0, 0, 1'b1);
        send_pixel(16'h0001, 16'h0001, 1'b0);
        send_pixel(16'h0001, 16'h0001, 1'b1);

        run_phase(0, 0, 300, 1'b1);
        run_phase(69, 0, 30, 1'b0);
        run_phase(0, 69, 30, 1'b0);
        run_phase(21, 21, 30, 1'b0);

        drain();
        repeat (SEARCH_LAT + 100) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
sv/scd_pkg.sv
sv/scd_ifs.sv
sv/scd_cell.sv
sv/scanline_code_disparity_search.sv
sv/scd_chk.sv
test/tb_scanline_code_disparity_search.sv
